@@ sv/scpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpc_pkg
// Shared types, constants and the patch point table of the stop cell pedestal
// correction block.
// ----------------------------------------------------------------------------
package scpc_pkg;

  localparam int SAMPLE_COUNT = 1024;
  localparam int PATCH_COUNT  = 11;
  localparam int IDX_W        = 10;
  localparam int SAMPLE_W     = 16;
  localparam int PNUM_W       = 4;
  localparam int MEAN_W       = 20;
  localparam int CORR_W       = 21;
  localparam int SUM_W        = 24;
  localparam int CNT_W        = 7;
  localparam int NUM_W        = 28;
  localparam int DEN_W        = 8;
  localparam int DIST_W       = 11;
  localparam int FRAC_BITS    = 4;

  // action codes on the input stream
  localparam logic [1:0] ACT_STORE   = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // register index on the config port
  localparam logic REG_VALID_FIRST = 1'b0;
  localparam logic REG_VALID_LAST  = 1'b1;

  localparam logic [IDX_W-1:0] VALID_FIRST_RST = 10'd1;
  localparam logic [IDX_W-1:0] VALID_LAST_RST  = 10'd950;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_COMPUTE,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [IDX_W-1:0]           sample_index;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [IDX_W-1:0]           stop_cell;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
  } window_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_RD_WAIT
  } back_state_t;

  // nominal start cell of each patch
  function automatic logic [IDX_W-1:0] patch_point(input logic [PNUM_W-1:0] p);
    logic [IDX_W-1:0] r;
    case (p)
      4'd0:    r = 10'd0;
      4'd1:    r = 10'd94;
      4'd2:    r = 10'd187;
      4'd3:    r = 10'd280;
      4'd4:    r = 10'd373;
      4'd5:    r = 10'd466;
      4'd6:    r = 10'd560;
      4'd7:    r = 10'd653;
      4'd8:    r = 10'd746;
      4'd9:    r = 10'd839;
      4'd10:   r = 10'd932;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // circular distance on the 1024 cell ring
  function automatic logic [DIST_W-1:0] circ_dist(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] e;
    d = (a > b) ? DIST_W'(a - b) : DIST_W'(b - a);
    e = DIST_W'(SAMPLE_COUNT) - d;
    return (d < e) ? d : e;
  endfunction

endpackage

@@ sv/scpc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpc_queue
// Small command FIFO between the front classifier and the back executor.
// ----------------------------------------------------------------------------
module scpc_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scpc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output scpc_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scpc_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

@@ sv/scpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpc_front
// Input word classifier and config register file (APB style).
// ----------------------------------------------------------------------------
module scpc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [39:0]             s_tdata,
  input  logic [1:0]              s_tuser,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output scpc_pkg::window_t       window,
  output logic                    push,
  output scpc_pkg::cmd_t          push_cmd,
  input  logic                    q_full
);

  logic [scpc_pkg::IDX_W-1:0] valid_first;
  logic [scpc_pkg::IDX_W-1:0] valid_last;
  logic                       known;
  scpc_pkg::cmd_kind_t        kind;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_first <= scpc_pkg::VALID_FIRST_RST;
      valid_last  <= scpc_pkg::VALID_LAST_RST;
    end else if (wr_en) begin
      if (paddr[2] == scpc_pkg::REG_VALID_FIRST) begin
        valid_first <= pwdata[scpc_pkg::IDX_W-1:0];
      end else begin
        valid_last <= pwdata[scpc_pkg::IDX_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == scpc_pkg::REG_VALID_FIRST) ?
                  {22'd0, valid_first} : {22'd0, valid_last};
  assign window = '{first: valid_first, last: valid_last};

  // action decode; unused code is taken and dropped
  always_comb begin
    known = 1'b1;
    kind  = scpc_pkg::CMD_STORE;
    unique case (s_tuser)
      scpc_pkg::ACT_STORE:   kind = scpc_pkg::CMD_STORE;
      scpc_pkg::ACT_COMPUTE: kind = scpc_pkg::CMD_COMPUTE;
      scpc_pkg::ACT_READ:    kind = scpc_pkg::CMD_READ;
      default:               known = 1'b0;
    endcase
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready && known;
  assign push_cmd = '{kind:         kind,
                      sample_index: s_tdata[9:0],
                      sample_value: s_tdata[25:10],
                      stop_cell:    s_tdata[35:26]};

endmodule

@@ sv/scpc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scpc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [scpc_pkg::NUM_W-1:0] num,
  input  logic [scpc_pkg::DEN_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [scpc_pkg::NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(scpc_pkg::NUM_W + 1);

  logic [scpc_pkg::DEN_W-1:0] den_r;
  logic [scpc_pkg::DEN_W-1:0] rem;
  logic [scpc_pkg::DEN_W:0]   rem_sh;
  logic [scpc_pkg::DEN_W:0]   diff;
  logic [STEP_W-1:0]          steps;

  assign rem_sh = {rem, quo[scpc_pkg::NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem <= diff[scpc_pkg::DEN_W-1:0];
        quo <= {quo[scpc_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[scpc_pkg::DEN_W-1:0];
        quo <= {quo[scpc_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == STEP_W'(scpc_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/scpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpc_back
// Executes queued commands: sample store, patch sweep and means, reads.
// ----------------------------------------------------------------------------
module scpc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  scpc_pkg::window_t       window,
  input  logic                    q_not_empty,
  input  scpc_pkg::cmd_t          q_head,
  output logic                    q_pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [63:0]             m_tdata,
  output logic                    m_tlast
);

  localparam int IW = scpc_pkg::IDX_W;
  localparam int PW = scpc_pkg::PNUM_W;
  localparam int SW = scpc_pkg::SUM_W;
  localparam int CW = scpc_pkg::CNT_W;
  localparam int MW = scpc_pkg::MEAN_W;
  localparam logic [PW-1:0] LAST_P = PW'(scpc_pkg::PATCH_COUNT - 1);

  scpc_pkg::back_state_t state, state_next;

  // sample memory
  logic signed [scpc_pkg::SAMPLE_W-1:0] mem [scpc_pkg::SAMPLE_COUNT];
  logic signed [scpc_pkg::SAMPLE_W-1:0] rd_data;
  logic                                 mem_we;
  logic                                 mem_re;
  logic [IW-1:0]                        mem_addr;

  // sweep
  logic [IW-1:0]        stop;
  logic [IW-1:0]        q_cnt;
  logic [IW-1:0]        q_d;
  logic [IW-1:0]        idx_d;
  logic                 rd_v;
  logic                 ok_d;
  logic signed [SW-1:0] sv;
  logic signed [SW-1:0] acc_sum;
  logic [CW-1:0]        acc_cnt;
  logic [PW-1:0]        acc_p;
  logic signed [SW-1:0] first_sum;
  logic [CW-1:0]        first_cnt;
  logic signed [SW-1:0] sums [scpc_pkg::PATCH_COUNT];
  logic [CW-1:0]        cnts [scpc_pkg::PATCH_COUNT];
  logic                 sum_we;
  logic [PW-1:0]        sum_wa;
  logic signed [SW-1:0] sum_wd;
  logic [CW-1:0]        cnt_wd;
  logic                 at_bound;

  // means and match
  logic signed [MW-1:0] means [scpc_pkg::PATCH_COUNT];
  logic [PW-1:0]        best_patch;
  logic [IW-1:0]        event_stop_cell;
  logic [scpc_pkg::DIST_W-1:0] best_d;
  logic [scpc_pkg::DIST_W-1:0] cur_d;
  logic [PW-1:0]        dp;
  logic [PW-1:0]        ep;
  logic signed [MW-1:0] mean_sel;

  // divider
  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic [scpc_pkg::NUM_W-1:0]  div_quo;
  logic signed [SW-1:0]        cur_sum;
  logic [CW-1:0]               cur_cnt;
  logic [SW-1:0]               mag;
  logic                        neg_r;
  logic signed [MW-1:0]        qmean;

  // read path
  logic [IW-1:0]                rd_idx;
  logic                         rd_ok;
  logic signed [scpc_pkg::CORR_W-1:0] corr;

  logic can_load;

  assign can_load = !m_tvalid || m_tready;

  // ---------------- sample memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= q_head.sample_value;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = q_head.sample_index;
    div_start  = 1'b0;
    unique case (state)
      scpc_pkg::ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            scpc_pkg::CMD_STORE:   mem_we = 1'b1;
            scpc_pkg::CMD_COMPUTE: state_next = scpc_pkg::ST_SWEEP;
            scpc_pkg::CMD_READ: begin
              mem_re     = 1'b1;
              state_next = scpc_pkg::ST_RD_WAIT;
            end
            default: state_next = scpc_pkg::ST_IDLE;
          endcase
        end
      end
      scpc_pkg::ST_SWEEP: begin
        mem_re   = 1'b1;
        mem_addr = q_cnt - stop;
        if (q_cnt == IW'(scpc_pkg::SAMPLE_COUNT - 1)) begin
          state_next = scpc_pkg::ST_DRAIN;
        end
      end
      scpc_pkg::ST_DRAIN: state_next = scpc_pkg::ST_DIV_START;
      scpc_pkg::ST_DIV_START: begin
        if (cur_cnt == '0) begin
          if (dp == LAST_P) begin
            state_next = scpc_pkg::ST_EMIT;
          end
        end else begin
          div_start  = 1'b1;
          state_next = scpc_pkg::ST_DIV_WAIT;
        end
      end
      scpc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (dp == LAST_P) ? scpc_pkg::ST_EMIT : scpc_pkg::ST_DIV_START;
        end
      end
      scpc_pkg::ST_EMIT: begin
        if (can_load && ep == LAST_P) begin
          state_next = scpc_pkg::ST_IDLE;
        end
      end
      scpc_pkg::ST_RD_WAIT: begin
        if (can_load) begin
          state_next = scpc_pkg::ST_IDLE;
        end
      end
      default: state_next = scpc_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sweep address stage ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == scpc_pkg::ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    if (state == scpc_pkg::ST_IDLE && q_not_empty) begin
      stop   <= q_head.stop_cell;
      rd_idx <= q_head.sample_index;
      q_cnt  <= '0;
    end else if (state == scpc_pkg::ST_SWEEP) begin
      q_cnt <= q_cnt + 1'b1;
    end
    q_d   <= q_cnt;
    idx_d <= mem_addr;
  end

  // ---------------- sweep accumulate stage ----------------
  assign ok_d     = (idx_d >= window.first) && (idx_d <= window.last);
  assign sv       = ok_d ? SW'(rd_data) : '0;
  assign at_bound = (acc_p != LAST_P) && (q_d == scpc_pkg::patch_point(acc_p + 1'b1));

  always_comb begin
    sum_we = rd_v && (at_bound || q_d == IW'(scpc_pkg::SAMPLE_COUNT - 1));
    sum_wa = at_bound ? acc_p : LAST_P;
    sum_wd = at_bound ? acc_sum + sv : acc_sum + sv + first_sum;
    cnt_wd = at_bound ? acc_cnt + CW'(ok_d) : acc_cnt + CW'(ok_d) + first_cnt;
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sums[sum_wa] <= sum_wd;
      cnts[sum_wa] <= cnt_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_p <= '0;
    end else if (rd_v) begin
      if (q_d == '0) begin
        acc_p <= '0;
      end else if (at_bound) begin
        acc_p <= acc_p + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      if (q_d == '0) begin
        first_sum <= sv;
        first_cnt <= CW'(ok_d);
        acc_sum   <= sv;
        acc_cnt   <= CW'(ok_d);
      end else if (at_bound) begin
        acc_sum <= sv;
        acc_cnt <= CW'(ok_d);
      end else begin
        acc_sum <= acc_sum + sv;
        acc_cnt <= acc_cnt + CW'(ok_d);
      end
    end
  end

  // ---------------- means: rounding divide per patch ----------------
  assign cur_sum = sums[dp];
  assign cur_cnt = cnts[dp];
  assign mag     = cur_sum[SW-1] ? SW'(-cur_sum) : SW'(cur_sum);
  assign qmean   = neg_r ? -MW'(div_quo) : MW'(div_quo);
  assign cur_d   = scpc_pkg::circ_dist(stop, scpc_pkg::patch_point(dp));

  scpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({1'b0, mag[21:0], 5'b0} + scpc_pkg::NUM_W'(cur_cnt)),
    .den   ({cur_cnt, 1'b0}),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= cur_sum[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dp              <= '0;
      ep              <= '0;
      best_patch      <= '0;
      event_stop_cell <= '0;
      best_d          <= '0;
      for (int i = 0; i < scpc_pkg::PATCH_COUNT; i++) begin
        means[i] <= '0;
      end
    end else begin
      if (state == scpc_pkg::ST_DRAIN) begin
        dp              <= '0;
        ep              <= '0;
        event_stop_cell <= stop;
      end
      // nearest patch, lowest number wins a tie
      if (state == scpc_pkg::ST_DIV_START) begin
        if (dp == '0 || cur_d < best_d) begin
          best_d     <= cur_d;
          best_patch <= dp;
        end
        if (cur_cnt == '0) begin
          means[dp] <= '0;
          if (dp != LAST_P) begin
            dp <= dp + 1'b1;
          end
        end
      end
      if (state == scpc_pkg::ST_DIV_WAIT && div_done) begin
        means[dp] <= qmean;
        if (dp != LAST_P) begin
          dp <= dp + 1'b1;
        end
      end
      if (state == scpc_pkg::ST_EMIT && can_load) begin
        ep <= ep + 1'b1;
      end
    end
  end

  // ---------------- result word ----------------
  assign mean_sel = means[(state == scpc_pkg::ST_EMIT) ? ep : best_patch];
  assign rd_ok    = (rd_idx >= window.first) && (rd_idx <= window.last);
  assign corr     = rd_ok ? (scpc_pkg::CORR_W'(mean_sel) -
                             (scpc_pkg::CORR_W'(rd_data) <<< scpc_pkg::FRAC_BITS)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= (state == scpc_pkg::ST_EMIT) || (state == scpc_pkg::ST_RD_WAIT);
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      if (state == scpc_pkg::ST_EMIT) begin
        m_tdata <= {7'd0, 1'b0, 10'd0, 21'd0, (ep == best_patch), mean_sel, ep};
        m_tlast <= (ep == LAST_P);
      end else begin
        m_tdata <= {7'd0, rd_ok, IW'(rd_idx + event_stop_cell + 1'b1), corr, 1'b1,
                    mean_sel, best_patch};
        m_tlast <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_drain_last_patch: assert property (@(posedge clk) disable iff (rst)
    (state == scpc_pkg::ST_DRAIN) |-> (acc_p == LAST_P))
    else $error("sweep ended before the last patch");
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == scpc_pkg::ST_IDLE) |-> !div_busy) else $error("divider busy in idle");
`endif

endmodule

@@ sv/stop_cell_patch_pedestal_correct.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_cell_patch_pedestal_correct
// Stop cell patch pedestal correction: sample store, patch means, correction.
// ----------------------------------------------------------------------------
// A store word is written to the sample memory as it leaves the queue. A
// compute word sweeps all 1024 samples through the single memory read port,
// then divides each non-empty patch in the shared bit-serial divider (11
// patches), then emits 11 result words, one per cycle while the sink is
// ready. A read word's memory data is registered, then its result word is
// registered at the output once the sink can take it. Words are queued
// (QUEUE_DEPTH deep) so the input side keeps accepting while the executor
// works, until the queue is full. The sample store needs no clear.
module stop_cell_patch_pedestal_correct #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // sample_index[9:0], sample_value[25:10], stop_cell[35:26]
  input  logic [1:0]  s_tuser,  // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // patch_number[3:0], patch_avg[23:4], is_matched[24],
                                // corrected_value[45:25], cell_bin[55:46], index_valid[56]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  scpc_pkg::window_t window;
  scpc_pkg::cmd_t    push_cmd;
  scpc_pkg::cmd_t    head;
  logic              push;
  logic              full;
  logic              not_empty;
  logic              pop;

  scpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .window   (window),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (full)
  );

  scpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  scpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .window      (window),
    .q_not_empty (not_empty),
    .q_head      (head),
    .q_pop       (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stop cell patch pedestal correction block.
// Stores samples, runs patch mean computes and corrected reads over several
// valid windows and handshake pressure settings. Every result word is
// compared against an in-bench prediction of the patch means and corrections.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_VALID_FIRST = 3'd0;
  localparam logic [2:0] ADDR_VALID_LAST  = 3'd4;
  localparam int RANDOM_PER_PHASE = 25;
  // only this low region is written, bar one directed store at cell 1023; non-empty windows stay inside it
  localparam int FILL_COUNT = 32;

  typedef struct packed {
    logic [1:0]                    act;
    logic [scpc_pkg::IDX_W-1:0]    idx;
    logic [scpc_pkg::SAMPLE_W-1:0] val;
    logic [scpc_pkg::IDX_W-1:0]    stop;
  } cmd_word_t;

  typedef struct packed {
    logic [scpc_pkg::PNUM_W-1:0] pnum;
    logic [scpc_pkg::MEAN_W-1:0] mean;
    logic                        matched;
    logic [scpc_pkg::CORR_W-1:0] corr;
    logic [scpc_pkg::IDX_W-1:0]  bin;
    logic                        ivalid;
    logic                        last;
  } result_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;  // sample_index[9:0], sample_value[25:10], stop_cell[35:26]
  logic [1:0]  s_tuser;  // action[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;  // patch_number[3:0], patch_avg[23:4], is_matched[24],
                         // corrected_value[45:25], cell_bin[55:46], index_valid[56]
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stop_cell_patch_pedestal_correct uut (.*);

  // bench copy of the block state
  int unsigned point_tbl [scpc_pkg::PATCH_COUNT] =
    '{0, 94, 187, 280, 373, 466, 560, 653, 746, 839, 932};
  logic signed [scpc_pkg::SAMPLE_W-1:0] wave_mem [scpc_pkg::SAMPLE_COUNT];
  int                         patch_avg [scpc_pkg::PATCH_COUNT];
  int unsigned                nearest_patch;
  int unsigned                event_stop;
  int unsigned                win_first;
  int unsigned                win_last;

  cmd_word_t    cmd_pending [$];
  result_word_t result_due [$];
  cmd_word_t    cur_cmd;
  logic         took;
  int           idle_pct;
  int           stall_pct;
  int           errors;
  int           words_in;
  int           words_out;
  int           computes;
  int           reads;

  function automatic bit in_win(int unsigned i);
    return i >= win_first && i <= win_last;
  endfunction

  // rounded mean of a circular range, 4 fraction bits, ties away from zero
  function automatic int range_avg(int unsigned from, int unsigned to);
    longint sum, cnt, mag, q;
    int unsigned i;
    sum = 0;
    cnt = 0;
    i = from;
    for (int s = 0; s < scpc_pkg::SAMPLE_COUNT; s++) begin
      if (in_win(i)) begin
        sum += wave_mem[i];
        cnt++;
      end
      if (i == to) break;
      i = (i + 1) % scpc_pkg::SAMPLE_COUNT;
    end
    if (cnt == 0) return 0;
    mag = (sum < 0) ? -sum : sum;
    q = (2 * mag * 16 + cnt) / (2 * cnt);
    return (sum < 0) ? int'(-q) : int'(q);
  endfunction

  function automatic int unsigned ring_dist(int unsigned a, int unsigned b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return (d < scpc_pkg::SAMPLE_COUNT - d) ? d : scpc_pkg::SAMPLE_COUNT - d;
  endfunction

  // update the bench state for one accepted word and queue its results
  function automatic void predict_word(cmd_word_t c);
    int unsigned starts [scpc_pkg::PATCH_COUNT];
    int unsigned best_d, d;
    result_word_t r;
    int corr;
    case (c.act)
      scpc_pkg::ACT_STORE: wave_mem[c.idx] = c.val;
      scpc_pkg::ACT_COMPUTE: begin
        for (int p = 0; p < scpc_pkg::PATCH_COUNT; p++)
          starts[p] = (point_tbl[p] + scpc_pkg::SAMPLE_COUNT - c.stop) % scpc_pkg::SAMPLE_COUNT;
        for (int p = 0; p < scpc_pkg::PATCH_COUNT; p++)
          patch_avg[p] = range_avg(starts[p], starts[(p + 1) % scpc_pkg::PATCH_COUNT]);
        best_d = 32'hFFFF_FFFF;
        for (int p = 0; p < scpc_pkg::PATCH_COUNT; p++) begin
          d = ring_dist(c.stop, point_tbl[p]);
          if (d < best_d) begin
            best_d = d;
            nearest_patch = p;
          end
        end
        event_stop = c.stop;
        for (int p = 0; p < scpc_pkg::PATCH_COUNT; p++) begin
          r.pnum = scpc_pkg::PNUM_W'(p);
          r.mean = scpc_pkg::MEAN_W'(patch_avg[p]);
          r.matched = (p == nearest_patch);
          r.corr = '0;
          r.bin = '0;
          r.ivalid = 1'b0;
          r.last = (p == scpc_pkg::PATCH_COUNT - 1);
          result_due.push_back(r);
        end
        computes++;
      end
      scpc_pkg::ACT_READ: begin
        corr = in_win(c.idx) ? patch_avg[nearest_patch] - int'(wave_mem[c.idx]) * 16 : 0;
        r.pnum = scpc_pkg::PNUM_W'(nearest_patch);
        r.mean = scpc_pkg::MEAN_W'(patch_avg[nearest_patch]);
        r.matched = 1'b1;
        r.corr = scpc_pkg::CORR_W'(corr);
        r.bin = scpc_pkg::IDX_W'((c.idx + event_stop + 1) % scpc_pkg::SAMPLE_COUNT);
        r.ivalid = in_win(c.idx);
        r.last = 1'b1;
        result_due.push_back(r);
        reads++;
      end
      default: ;
    endcase
  endfunction

  function automatic void push_cmd(logic [1:0] a, int unsigned i, int v, int unsigned s);
    cmd_word_t c;
    c.act = a;
    c.idx = scpc_pkg::IDX_W'(i);
    c.val = scpc_pkg::SAMPLE_W'(v);
    c.stop = scpc_pkg::IDX_W'(s);
    cmd_pending.push_back(c);
  endfunction

  // mostly stores and reads in the written region, some computes, a little
  // unused action noise
  function automatic void push_random;
    int unsigned r;
    cmd_word_t c;
    r = $urandom_range(99);
    c.idx = scpc_pkg::IDX_W'($urandom_range(FILL_COUNT - 1));
    c.val = scpc_pkg::SAMPLE_W'($urandom);
    c.stop = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 10'd1023 : 10'd0)
                                       : scpc_pkg::IDX_W'($urandom_range(1023));
    if (r < 50)      c.act = scpc_pkg::ACT_STORE;
    else if (r < 82) c.act = scpc_pkg::ACT_READ;
    else if (r < 96) c.act = scpc_pkg::ACT_COMPUTE;
    else             c.act = ACT_UNUSED;
    cmd_pending.push_back(c);
  endfunction

  task automatic reg_write(logic [2:0] addr, int unsigned value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ADDR_VALID_FIRST) win_first = value & 10'h3FF;
    else win_last = value & 10'h3FF;
  endtask

  task automatic set_window(int unsigned first, int unsigned last);
    reg_write(ADDR_VALID_FIRST, first);
    reg_write(ADDR_VALID_LAST, last);
  endtask

  // drain everything, then give queued stores time to retire
  task automatic wait_idle;
    do @(posedge clk);
    while (!(cmd_pending.size() == 0 && !s_tvalid && result_due.size() == 0));
    repeat (100) @(posedge clk);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // input side: record accepted words
  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        predict_word(cur_cmd);
        words_in++;
      end
    end
  end

  // input side driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= scpc_pkg::ACT_STORE;
    end else if (!s_tvalid || took) begin
      if (cmd_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cur_cmd = cmd_pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= cur_cmd.act;
        s_tdata <= {4'b0, cur_cmd.stop, cur_cmd.val, cur_cmd.idx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side ready
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // output monitor
  always @(posedge clk) begin
    result_word_t e, a;
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      a.pnum = m_tdata[3:0];
      a.mean = m_tdata[23:4];
      a.matched = m_tdata[24];
      a.corr = m_tdata[45:25];
      a.bin = m_tdata[55:46];
      a.ivalid = m_tdata[56];
      a.last = m_tlast;
      if (result_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: data %h last %b", m_tdata, m_tlast);
      end else begin
        e = result_due.pop_front();
        if (a != e) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: exp patch %0d mean %h match %b corr %h bin %0d ok %b last %b",
                      " / got patch %0d mean %h match %b corr %h bin %0d ok %b last %b"},
                     e.pnum, e.mean, e.matched, e.corr, e.bin, e.ivalid, e.last,
                     a.pnum, a.mean, a.matched, a.corr, a.bin, a.ivalid, a.last);
        end
      end
    end
  end

  // stimulus
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    computes = 0;
    reads = 0;
    for (int i = 0; i < scpc_pkg::SAMPLE_COUNT; i++) wave_mem[i] = '0;
    for (int p = 0; p < scpc_pkg::PATCH_COUNT; p++) patch_avg[p] = 0;
    nearest_patch = 0;
    event_stop = 0;
    win_first = scpc_pkg::VALID_FIRST_RST;
    win_last = scpc_pkg::VALID_LAST_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // keep means and reads inside the written region
    set_window(1, FILL_COUNT - 2);

    // fill the low region so no read or mean touches an unwritten cell
    for (int i = 0; i < FILL_COUNT; i++)
      push_cmd(scpc_pkg::ACT_STORE, i,
               (i % 7 == 0) ? -32768 : (i % 5 == 0) ? 32767 : int'($urandom), 0);

    // directed: extremes, ties in the nearest patch, window edges, unused action
    push_cmd(scpc_pkg::ACT_STORE, 0, -32768, 0);
    push_cmd(scpc_pkg::ACT_STORE, 1023, 32767, 0);
    push_cmd(scpc_pkg::ACT_STORE, 1, 32767, 0);
    push_cmd(scpc_pkg::ACT_COMPUTE, 0, 0, 0);
    push_cmd(scpc_pkg::ACT_READ, 0, 0, 0);
    push_cmd(scpc_pkg::ACT_READ, 1, 0, 0);
    push_cmd(scpc_pkg::ACT_READ, FILL_COUNT - 2, 0, 0);
    push_cmd(scpc_pkg::ACT_READ, FILL_COUNT - 1, 0, 0);
    push_cmd(scpc_pkg::ACT_COMPUTE, 0, 0, 47);
    push_cmd(scpc_pkg::ACT_COMPUTE, 0, 0, 48);
    push_cmd(scpc_pkg::ACT_COMPUTE, 0, 0, 978);
    push_cmd(scpc_pkg::ACT_COMPUTE, 0, 0, 1023);
    push_cmd(scpc_pkg::ACT_READ, 1023, -1, 1023);
    push_cmd(ACT_UNUSED, 1023, -1, 1023);
    push_cmd(scpc_pkg::ACT_COMPUTE, 0, 0, 512);
    push_cmd(scpc_pkg::ACT_READ, 20, 0, 0);
    wait_idle();

    // phases: window setting and handshake pressure
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin set_window(0, FILL_COUNT - 1); idle_pct = 0;  stall_pct = 0;  end
        1: begin set_window(1023, 0);           idle_pct = 69; stall_pct = 0;  end
        2: begin set_window(5, 5);              idle_pct = 0;  stall_pct = 69; end
        default: begin
          set_window($urandom_range(15), $urandom_range(FILL_COUNT - 1, 16));
          idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        push_random();
        if (n % 10 == 0)
          push_cmd(scpc_pkg::ACT_COMPUTE, 0, 0, $urandom_range(scpc_pkg::SAMPLE_COUNT - 1));
      end
      wait_idle();
    end

    $display("covered %0d input words, %0d computes, %0d reads, %0d result words",
             words_in, computes, reads, words_out);
    $display("window settings incl. empty and single index, with idle and stall phases");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
